// ===== rtl/ddpq_pkg.sv =====
// ----------------------------------------------------------------------------
// ddpq_pkg: shared types and constants of the due date priority queue
// Entry layout, status codes, the cell control group and the key function.
// ----------------------------------------------------------------------------
package ddpq_pkg;

    localparam int CAPACITY_DEF        = 16;
    localparam int MAX_NAME_LENGTH_DEF = 11;

    localparam int HANDLE_W = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int LENGTH_W = 4;
    localparam int OCC_W    = 5;
    localparam int KEY_W    = MONTH_W + DAY_W;

    localparam logic [DAY_W-1:0]   DAY_MAX   = DAY_W'(31);
    localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);

    typedef enum logic [2:0] {
        ST_ENQUEUED   = 3'd0,
        ST_BAD_LENGTH = 3'd1,
        ST_BAD_DAY    = 3'd2,
        ST_BAD_MONTH  = 3'd3,
        ST_FULL       = 3'd4,
        ST_DEQUEUED   = 3'd5,
        ST_EMPTY      = 3'd6
    } status_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } entry_t;

    // Broadcast to every cell; at most one of the two is set in a cycle.
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

    function automatic logic [KEY_W-1:0] key_of(entry_t e);
        return {e.month, e.day};
    endfunction

endpackage

// ===== rtl/ddpq_cell.sv =====
// ----------------------------------------------------------------------------
// ddpq_cell: one slot of the sorted shift-register queue
// Holds one entry, compares it with the entry being inserted, and shifts
// toward the head on a dequeue or toward the tail on an insert ahead of it.
// ----------------------------------------------------------------------------
module ddpq_cell
    import ddpq_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  logic       occupied,
    input  logic       left_occupied,
    input  logic       left_greater,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       greater
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   take_new;

    // Equal keys are not greater, so a new entry lands behind them.
    assign greater = occupied && (key_of(entry_reg) > key_of(new_entry));

    // The insert point is the first cell that is greater, or the first free
    // cell when no held entry is greater.
    assign take_new = ctrl.enq && !left_greater &&
                      (greater || (!occupied && left_occupied));

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.deq) begin
            entry_next = right_entry;
        end else if (ctrl.enq && left_greater) begin
            entry_next = left_entry;
        end else if (take_new) begin
            entry_next = new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/due_date_priority_queue.sv =====
// ----------------------------------------------------------------------------
// due_date_priority_queue: bounded priority queue keyed by (month, day)
// A row of cells keeps the entries sorted earliest first; equal keys leave
// in arrival order. Each request word returns one result word.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                         | tuser
//  s_       | in        | item_handle, due_month, due_day,           | req_type
//           |           | name_length, zero pad to 32                |
//  m_       | out       | out_handle, out_month, out_day,            | status
//           |           | occupancy, zero pad to 32                  |
//
// One request is taken every cycle while s_tready is high; every cell
// compares its key with the incoming key in the same cycle, so the row
// shifts in one step. Each result word is registered in the output register.
// A skid register holds one more result while the output stalls; s_tready
// drops only when both are full.
// Reset clears the entry count and the output handshake; no clearing pass.
// ----------------------------------------------------------------------------
module due_date_priority_queue
    import ddpq_pkg::*;
#(
    parameter int CAPACITY        = CAPACITY_DEF,
    parameter int MAX_NAME_LENGTH = MAX_NAME_LENGTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // item_handle[15:0], due_month[19:16], due_day[24:20], name_length[28:25]
    input  logic [31:0] s_tdata,
    // req_type[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_handle[15:0], out_month[19:16], out_day[24:20], occupancy[29:25]
    output logic [31:0] m_tdata,
    // status[2:0]
    output logic [2:0]  m_tuser
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0]       CAP_COUNT = CW'(CAPACITY);
    localparam logic [LENGTH_W-1:0] LEN_MAX   = LENGTH_W'(MAX_NAME_LENGTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          skid_valid_reg;
    result_t       out_reg;
    result_t       skid_reg;

    logic          accept;
    logic          is_deq;
    entry_t        req_entry;
    logic [LENGTH_W-1:0] req_length;
    cell_ctrl_t    ctrl;
    result_t       res;

    entry_t        cell_entry   [CAPACITY];
    logic          cell_greater [CAPACITY];
    logic          cell_occ     [CAPACITY];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign is_deq           = s_tuser[0];
    assign req_entry.handle = s_tdata[15:0];
    assign req_entry.month  = s_tdata[19:16];
    assign req_entry.day    = s_tdata[24:20];
    assign req_length       = s_tdata[28:25];

    always_comb begin
        ctrl       = '0;
        count_next = count_reg;
        res        = '0;
        if (is_deq) begin
            if (count_reg == '0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status = ST_DEQUEUED;
                res.handle = cell_entry[0].handle;
                res.month  = cell_entry[0].month;
                res.day    = cell_entry[0].day;
                ctrl.deq   = accept;
                count_next = CW'(count_reg - 1'b1);
            end
        end else begin
            priority if (req_length == '0 || req_length > LEN_MAX) begin
                res.status = ST_BAD_LENGTH;
            end else if (req_entry.day == '0 || req_entry.day > DAY_MAX) begin
                res.status = ST_BAD_DAY;
            end else if (req_entry.month == '0 || req_entry.month > MONTH_MAX) begin
                res.status = ST_BAD_MONTH;
            end else if (count_reg >= CAP_COUNT) begin
                res.status = ST_FULL;
            end else begin
                res.status = ST_ENQUEUED;
                ctrl.enq   = accept;
                count_next = CW'(count_reg + 1'b1);
            end
        end
        res.occupancy = OCC_W'(count_next);
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        entry_t left_entry;
        entry_t right_entry;
        logic   left_greater;
        logic   left_occ;

        assign cell_occ[i] = IDX < count_reg;

        if (i == 0) begin : g_head
            assign left_entry   = '0;
            assign left_greater = 1'b0;
            assign left_occ     = 1'b1;
        end else begin : g_body
            assign left_entry   = cell_entry[i-1];
            assign left_greater = cell_greater[i-1];
            assign left_occ     = cell_occ[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        ddpq_cell u_cell (
            .aclk          (aclk),
            .ctrl          (ctrl),
            .new_entry     (req_entry),
            .occupied      (cell_occ[i]),
            .left_occupied (left_occ),
            .left_greater  (left_greater),
            .left_entry    (left_entry),
            .right_entry   (right_entry),
            .entry         (cell_entry[i]),
            .greater       (cell_greater[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_reg       <= res;
                    out_valid_reg <= accept;
                end
            end else if (accept) begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {2'b00, out_reg.occupancy, out_reg.day, out_reg.month,
                       out_reg.handle};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_COUNT)
        else $error("entry count exceeds capacity");

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held while output register is empty");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.enq |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("stored enqueue did not raise the count");

    a_deq_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.deq |=> count_reg == CW'($past(count_reg) - 1'b1))
        else $error("dequeue did not lower the count");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("count changed without an accepted word");

endmodule
